// ----- src/rcf_pkg.sv -----
// ----------------------------------------------------------------------------
// rcf_pkg: shared types and constants of the regularised friction core
// Word layouts, stage counts, fixed-point constants and register indexes.
// ----------------------------------------------------------------------------
package rcf_pkg;

  // Pipeline shape.
  localparam int SQ_STAGES    = 31;                 // one root bit per stage
  localparam int DV_STAGES    = 33;                 // one quotient bit per stage
  localparam int HORNER_STEPS = 8;
  localparam int EXP_LAT      = 2 * HORNER_STEPS + 5;
  localparam int MU_DLY       = SQ_STAGES + DV_STAGES - EXP_LAT;
  localparam int PIPE_LAT     = 4 + SQ_STAGES + DV_STAGES + 3;

  // Register reset values.
  localparam logic [30:0] ITS_RESET     = 31'd65536;
  localparam logic [17:0] STATIC_RESET  = 18'd19661;
  localparam logic [17:0] DYNAMIC_RESET = 18'd13107;

  // Fixed-point constants.
  localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;  // floor(v/10) = (v*M) >> 35
  localparam logic [16:0] LOG2E_Q16   = 17'd94548;
  localparam logic [31:0] LN2_Q32     = 32'd2977044472;
  localparam logic [61:0] EPS2_Q32    = 62'd429497;
  localparam logic [32:0] ONE_Q32     = 33'h1_0000_0000;
  localparam logic [31:0] SAT_POS     = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG     = 32'h8000_0000;

  // Reciprocal multipliers for the Horner divisors 8 down to 1.
  localparam logic [32:0] HORNER_MAGIC [HORNER_STEPS] = '{
    33'd1, 33'h1_2492_4925, 33'h0_AAAA_AAAB, 33'h0_CCCC_CCCD,
    33'd1, 33'h0_AAAA_AAAB, 33'd1, 33'd1
  };
  localparam int HORNER_SHIFT [HORNER_STEPS] = '{3, 35, 34, 34, 2, 33, 1, 0};

  typedef enum logic [1:0] {
    CFG_INV_STEP = 2'd0,
    CFG_STATIC   = 2'd1,
    CFG_DYNAMIC  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic        [30:0] slip_amount;
    logic signed [31:0] normal_force;
    logic signed [31:0] tangent_gap;
    logic        [30:0] tangent_penalty;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] tangent_force;
    logic               slipping;
    logic        [17:0] friction_value;
  } out_word_t;

  // Per-item data that rides alongside the root and quotient stages.
  typedef struct packed {
    logic [30:0] v;
    logic [31:0] nmag;
    logic        gneg;
    logic        gnz;
    logic [46:0] trial;
  } side_t;

  typedef struct packed {
    logic [32:0] rem;
    logic [30:0] root;
    logic [61:0] x;
    side_t       side;
  } sq_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [32:0] q;
    logic [30:0] d;
    side_t       side;
  } dv_t;

  typedef struct packed {
    logic [31:0] y;
    logic [32:0] r;
    logic        kbig;
    logic [4:0]  ksh;
  } hx_t;

  typedef struct packed {
    logic [31:0] y;
    logic [31:0] p;
    logic        kbig;
    logic [4:0]  ksh;
  } hp_t;

endpackage

// ----- src/regularized_coulomb_friction_core.sv -----
// ----------------------------------------------------------------------------
// regularized_coulomb_friction_core: pipelined regularised Coulomb friction
// Stribeck-type friction coefficient and stick/slip force for one contact
// point per word, signed Q16.16 with saturation.
// ----------------------------------------------------------------------------
// Usage.
// An input word (in_word) is taken at every rising edge at which start is high
// and busy is low. busy is high only during reset and the cycle after it, so
// a new word may be offered in every cycle and one is taken per clock.
// Each result word appears on out_word for exactly one cycle, flagged by
// out_valid, once its input word has run through every stage. Results leave
// in the order the words came in. The receiver cannot hold results off, so
// the pipeline never stalls and nothing is ever buffered beyond its stages.
// The latency is set by the bit-serial square root (31 stages) followed by
// the bit-serial divider (33 stages); the exponential chain runs alongside
// and its coefficient waits in a delay line. Throughput is one word a clock.
// Configuration words arrive on the cfg_ channel (always ready) and should be
// written while no word is in flight. Reset empties the pipeline and loads
// the reset values of the three registers.
// ----------------------------------------------------------------------------
module regularized_coulomb_friction_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  rcf_pkg::in_word_t    in_word,
  output logic                 out_valid,
  output rcf_pkg::out_word_t   out_word,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data
);
  import rcf_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers and handshake control.
  // --------------------------------------------------------------------------
  logic [30:0] its_r;
  logic [17:0] st_r;
  logic [17:0] dyn_r;
  logic        busy_r;
  logic [PIPE_LAT-1:0] vld_r;
  logic        accept;

  assign cfg_ready = 1'b1;
  assign busy      = busy_r;
  assign accept    = start && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      its_r  <= ITS_RESET;
      st_r   <= STATIC_RESET;
      dyn_r  <= DYNAMIC_RESET;
      busy_r <= 1'b1;
      vld_r  <= '0;
    end else begin
      busy_r <= 1'b0;
      vld_r  <= {vld_r[PIPE_LAT-2:0], accept};
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_INV_STEP: its_r <= cfg_data[30:0];
          CFG_STATIC:   st_r  <= cfg_data[17:0];
          CFG_DYNAMIC:  dyn_r <= cfg_data[17:0];
          default: ;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: magnitudes, velocity product and trial force product.
  // --------------------------------------------------------------------------
  logic [31:0] nmag_c, gmag_c;
  logic [61:0] vprod_r;
  logic [62:0] tprod1_r;
  logic [31:0] nmag1_r;
  logic        gneg1_r, gnz1_r;

  always_comb begin
    nmag_c = in_word.normal_force[31] ? (~$unsigned(in_word.normal_force) + 32'd1)
                                      : $unsigned(in_word.normal_force);
    gmag_c = in_word.tangent_gap[31] ? (~$unsigned(in_word.tangent_gap) + 32'd1)
                                     : $unsigned(in_word.tangent_gap);
  end

  always_ff @(posedge clk) begin
    vprod_r  <= 62'(in_word.slip_amount) * 62'(its_r);
    tprod1_r <= 63'(in_word.tangent_penalty) * 63'(gmag_c);
    nmag1_r  <= nmag_c;
    gneg1_r  <= in_word.tangent_gap[31];
    gnz1_r   <= (gmag_c != 32'd0);
  end

  // --------------------------------------------------------------------------
  // Stage 2: velocity saturates to 31 bits; trial magnitude is kept whole.
  // --------------------------------------------------------------------------
  side_t side2_r, side2_nxt;

  always_comb begin
    side2_nxt.v     = (|vprod_r[61:47]) ? SAT_POS[30:0] : vprod_r[46:16];
    side2_nxt.nmag  = nmag1_r;
    side2_nxt.gneg  = gneg1_r;
    side2_nxt.gnz   = gnz1_r;
    side2_nxt.trial = tprod1_r[62:16];
  end

  always_ff @(posedge clk) begin
    side2_r <= side2_nxt;
  end

  // --------------------------------------------------------------------------
  // Stage 3: v squared for the root, v times the reciprocal of ten.
  // --------------------------------------------------------------------------
  side_t       side3_r;
  logic [61:0] vsq_r;
  logic [62:0] aprod_r;

  always_ff @(posedge clk) begin
    side3_r <= side2_r;
    vsq_r   <= 62'(side2_r.v) * 62'(side2_r.v);
    aprod_r <= 63'(side2_r.v) * 63'(DIV10_MAGIC);
  end

  // --------------------------------------------------------------------------
  // Stage 4: radicand v^2 + eps^2, and a * log2(e) for the exponential.
  // --------------------------------------------------------------------------
  side_t       side4_r;
  logic [61:0] rad_r;
  logic [44:0] lprod_r;

  always_ff @(posedge clk) begin
    side4_r <= side3_r;
    rad_r   <= vsq_r + EPS2_Q32;
    lprod_r <= 45'(aprod_r[62:35]) * 45'(LOG2E_Q16);
  end

  // --------------------------------------------------------------------------
  // Exponential branch. exp(-a) = 2^-k * exp(-f*ln2), the fraction part by
  // an eight-step Horner series, each step one multiply stage and one
  // reciprocal-divide stage.
  // --------------------------------------------------------------------------
  logic [28:0] t_c;
  logic [47:0] yprod_r;
  logic        kbig_e1_r;
  logic [4:0]  ksh_e1_r;
  hx_t         hin0_r;
  hx_t         hin [HORNER_STEPS+1];
  hp_t         hp_r [HORNER_STEPS];
  hx_t         hd_r [HORNER_STEPS];

  assign t_c = lprod_r[44:16];

  always_ff @(posedge clk) begin
    yprod_r   <= 48'(t_c[15:0]) * 48'(LN2_Q32);
    kbig_e1_r <= |t_c[28:21];
    ksh_e1_r  <= t_c[20:16];
  end

  always_ff @(posedge clk) begin
    hin0_r.y    <= yprod_r[47:16];
    hin0_r.r    <= ONE_Q32;
    hin0_r.kbig <= kbig_e1_r;
    hin0_r.ksh  <= ksh_e1_r;
  end

  assign hin[0] = hin0_r;

  for (genvar j = 0; j < HORNER_STEPS; j++) begin : g_horner
    logic [64:0] mprod;
    logic [64:0] dprod;
    logic [64:0] dquot;

    assign mprod = 65'(hin[j].y) * 65'(hin[j].r);

    always_ff @(posedge clk) begin
      hp_r[j].y    <= hin[j].y;
      hp_r[j].p    <= mprod[63:32];
      hp_r[j].kbig <= hin[j].kbig;
      hp_r[j].ksh  <= hin[j].ksh;
    end

    assign dprod = 65'(hp_r[j].p) * 65'(HORNER_MAGIC[j]);
    assign dquot = dprod >> HORNER_SHIFT[j];

    always_ff @(posedge clk) begin
      hd_r[j].y    <= hp_r[j].y;
      hd_r[j].r    <= ONE_Q32 - {1'b0, dquot[31:0]};
      hd_r[j].kbig <= hp_r[j].kbig;
      hd_r[j].ksh  <= hp_r[j].ksh;
    end

    assign hin[j+1] = hd_r[j];
  end

  // Scale by 2^-k, blend static and dynamic values.
  logic [32:0] e_r;
  logic [50:0] term_c;
  logic [17:0] term_r;
  logic [17:0] mu0_r;
  logic [17:0] diff_c;
  logic        sge_c;
  logic [17:0] mud_r [MU_DLY];

  always_comb begin
    sge_c  = (st_r >= dyn_r);
    diff_c = sge_c ? (st_r - dyn_r) : (dyn_r - st_r);
    term_c = 51'(diff_c) * 51'(e_r);
  end

  always_ff @(posedge clk) begin
    e_r    <= hin[HORNER_STEPS].kbig ? 33'd0
                                     : (hin[HORNER_STEPS].r >> hin[HORNER_STEPS].ksh);
    term_r <= term_c[49:32];
    mu0_r  <= sge_c ? (dyn_r + term_r) : (dyn_r - term_r);
    mud_r[0] <= mu0_r;
    for (int i = 1; i < MU_DLY; i++) begin
      mud_r[i] <= mud_r[i-1];
    end
  end

  // --------------------------------------------------------------------------
  // Square root, one root bit per stage (restoring form).
  // --------------------------------------------------------------------------
  sq_t sq_in [SQ_STAGES+1];
  sq_t sq_r  [SQ_STAGES];

  assign sq_in[0] = '{rem: 33'd0, root: 31'd0, x: rad_r, side: side4_r};

  for (genvar i = 0; i < SQ_STAGES; i++) begin : g_sqrt
    logic [34:0] rem_sh;
    logic [34:0] test;
    sq_t         sq_nxt;

    always_comb begin
      rem_sh = {sq_in[i].rem[32:0], sq_in[i].x[61:60]};
      test   = {2'b00, sq_in[i].root, 2'b01};
      sq_nxt.x    = {sq_in[i].x[59:0], 2'b00};
      sq_nxt.side = sq_in[i].side;
      if (rem_sh >= test) begin
        sq_nxt.rem  = 33'(rem_sh - test);
        sq_nxt.root = {sq_in[i].root[29:0], 1'b1};
      end else begin
        sq_nxt.rem  = rem_sh[32:0];
        sq_nxt.root = {sq_in[i].root[29:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      sq_r[i] <= sq_nxt;
    end

    assign sq_in[i+1] = sq_r[i];
  end

  // --------------------------------------------------------------------------
  // Divider (v << 32) / s, one quotient bit per stage. The quotient never
  // exceeds 2^32, so the top thirty numerator bits go straight into the
  // starting remainder.
  // --------------------------------------------------------------------------
  dv_t dv_in [DV_STAGES+1];
  dv_t dv_r  [DV_STAGES];

  assign dv_in[0] = '{rem:  {2'b00, sq_in[SQ_STAGES].side.v[30:1]},
                      q:    33'd0,
                      d:    sq_in[SQ_STAGES].root,
                      side: sq_in[SQ_STAGES].side};

  for (genvar i = 0; i < DV_STAGES; i++) begin : g_div
    logic        nbit;
    logic [32:0] rem_sh;
    dv_t         dv_nxt;

    assign nbit = (i == 0) ? dv_in[i].side.v[0] : 1'b0;

    always_comb begin
      rem_sh      = {dv_in[i].rem, nbit};
      dv_nxt.d    = dv_in[i].d;
      dv_nxt.side = dv_in[i].side;
      if (rem_sh >= {2'b00, dv_in[i].d}) begin
        dv_nxt.rem = 32'(rem_sh - {2'b00, dv_in[i].d});
        dv_nxt.q   = {dv_in[i].q[31:0], 1'b1};
      end else begin
        dv_nxt.rem = rem_sh[31:0];
        dv_nxt.q   = {dv_in[i].q[31:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      dv_r[i] <= dv_nxt;
    end

    assign dv_in[i+1] = dv_r[i];
  end

  // --------------------------------------------------------------------------
  // Tail: mu = mu0 * g, the Coulomb limit, then stick/slip and saturation.
  // --------------------------------------------------------------------------
  logic [50:0] muprod_c;
  logic [17:0] mu_r;
  side_t       side_m_r;
  logic [49:0] limprod_c;
  logic [33:0] limit_r;
  logic [17:0] mu_l_r;
  side_t       side_l_r;

  assign muprod_c = 51'(mud_r[MU_DLY-1]) * 51'(dv_in[DV_STAGES].q);

  always_ff @(posedge clk) begin
    mu_r     <= muprod_c[49:32];
    side_m_r <= dv_in[DV_STAGES].side;
  end

  assign limprod_c = 50'(mu_r) * 50'(side_m_r.nmag);

  always_ff @(posedge clk) begin
    limit_r  <= limprod_c[49:16];
    mu_l_r   <= mu_r;
    side_l_r <= side_m_r;
  end

  logic        slip_c;
  logic [46:0] mag_c;
  logic [31:0] force_c;
  out_word_t   out_r;

  always_comb begin
    slip_c = side_l_r.gnz && (side_l_r.trial > {13'd0, limit_r});
    mag_c  = slip_c ? {13'd0, limit_r} : side_l_r.trial;
    if (side_l_r.gneg) begin
      force_c = (|mag_c[46:31]) ? SAT_NEG : (~mag_c[31:0] + 32'd1);
    end else begin
      force_c = (|mag_c[46:31]) ? SAT_POS : mag_c[31:0];
    end
  end

  always_ff @(posedge clk) begin
    out_r.tangent_force  <= $signed(force_c);
    out_r.slipping       <= slip_c;
    out_r.friction_value <= mu_l_r;
  end

  assign out_valid = vld_r[PIPE_LAT-1];
  assign out_word  = out_r;

  // --------------------------------------------------------------------------
  // Checks.
  // --------------------------------------------------------------------------
  // A clamped force with a zero coefficient must come out as zero.
  a_zero_mu_slip : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.slipping && out_word.friction_value == 18'd0)
      |-> (out_word.tangent_force == 32'sd0))
    else $error("slipping word with zero friction carries a non-zero force");

  // The regularised coefficient never exceeds the larger of the two values.
  a_mu_bound : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.friction_value <= st_r || out_word.friction_value <= dyn_r))
    else $error("friction coefficient above both static and dynamic values");

  // A word with a zero tangential gap never slips.
  a_slip_gap : assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[PIPE_LAT-2] && !side_l_r.gnz) |=> !out_word.slipping)
    else $error("slip reported for a zero tangential gap");

endmodule
